// ===== rtl/formation_slot_position_top_defines.svh =====
// Assertion macros shared by the block's modules.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef FORMATION_SLOT_POSITION_TOP_DEFINES_SVH
`define FORMATION_SLOT_POSITION_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define FSP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define FSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fsp_pkg.sv =====
`default_nettype none

package fsp_pkg;

  // Field widths of one request and one result.
  localparam int IDX_W  = 12;
  localparam int CAP_W  = 13;
  localparam int DIM_W  = 7;
  localparam int POS_W  = 15;

  // Largest legal grid dimension.
  localparam int MAX_DIM = 64;

  // Request packing in the input tdata, lowest bit first.
  localparam int IDX_LSB  = 0;
  localparam int CAP_LSB  = IDX_LSB + IDX_W;
  localparam int COLS_LSB = CAP_LSB + CAP_W;
  localparam int ROWS_LSB = COLS_LSB + DIM_W;
  localparam int IN_BITS  = ROWS_LSB + DIM_W;
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

  // Result packing in the output tdata, lowest bit first.
  localparam int OUT_BITS    = 2 * POS_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Datapath widths: a valid grid area never exceeds MAX_DIM squared.
  localparam int AREA_W = 13;
  localparam int PROD_W = AREA_W + DIM_W;

  // Growth of line shapes as shift amounts (4 and 16 columns per row).
  localparam int GROWTH_RANKS_SH = 2;
  localparam int GROWTH_STAG_SH  = 4;

  // Scatter hash: only the bits up to the y jitter bit are needed.
  localparam logic [31:0] SCATTER_MUL = 32'd2654435761;
  localparam int HASH_X_BIT = 16;
  localparam int HASH_Y_BIT = 24;
  localparam int HASH_W     = HASH_Y_BIT + 1;

  // Restoring divider: one quotient bit per cycle.
  localparam int DIV_STEPS = IDX_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Register map.
  localparam int PADDR_W = 4;
  localparam logic [1:0] REG_SHAPE_MODE  = 2'd0;
  localparam logic [1:0] REG_CENTERED_ON = 2'd1;
  localparam logic [1:0] REG_SWAP_AXES   = 2'd2;

  typedef enum logic [1:0] {
    MODE_GRID    = 2'd0,
    MODE_RANKS   = 2'd1,
    MODE_STAGGER = 2'd2,
    MODE_SCATTER = 2'd3
  } shape_mode_e;

  typedef struct packed {
    shape_mode_e mode;
    logic        centered;
    logic        swap;
  } fsp_cfg_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic setup;
    logic check;
    logic shell;
    logic colp;
    logic div;
    logic post_load;
  } fsp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic ok;
    logic hit;
    logic use_div;
    logic div_last;
  } fsp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/fsp_ctrl.sv =====
`default_nettype none

`include "formation_slot_position_top_defines.svh"

module fsp_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  input  wire fsp_pkg::fsp_sts_t sts_i,
  output fsp_pkg::fsp_cmd_t      cmd_o
);
  import fsp_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SETUP = 7'b0000010,
    ST_CHECK = 7'b0000100,
    ST_SHELL = 7'b0001000,
    ST_COLP  = 7'b0010000,
    ST_DIV   = 7'b0100000,
    ST_POST  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_fire;
  logic   out_free;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  // Sequencer: one request at a time, each phase issues one command.
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        cmd_o.capture = s_axis_tvalid;
        if (s_axis_tvalid) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = ST_CHECK;
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = sts_i.ok ? ST_SHELL : ST_POST;
      end
      ST_SHELL: begin
        cmd_o.shell = 1'b1;
        if (sts_i.hit) begin
          state_d = ST_COLP;
        end
      end
      ST_COLP: begin
        cmd_o.colp = 1'b1;
        state_d    = sts_i.use_div ? ST_DIV : ST_POST;
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_POST;
        end
      end
      ST_POST: begin
        // Hand the result to the output register once it is free.
        if (out_free) begin
          cmd_o.post_load = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register valid: set on load, cleared when the transfer completes.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.post_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;

  `FSP_ASSERT_NEXT(a_accept_starts_setup, in_fire, state_q == ST_SETUP, "accept did not start setup")
  `FSP_ASSERT_NOW(a_no_result_overwrite, cmd_o.post_load, out_free, "pending result overwritten")
  `FSP_ASSERT_NOW(a_valid_from_post, $rose(out_valid_q), $past(state_q == ST_POST), "result without post phase")

endmodule

`default_nettype wire

// ===== rtl/fsp_dp.sv =====
`default_nettype none

`include "formation_slot_position_top_defines.svh"

module fsp_dp (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic [fsp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  wire fsp_pkg::fsp_cfg_t                  cfg_i,
  input  wire fsp_pkg::fsp_cmd_t                  cmd_i,
  output fsp_pkg::fsp_sts_t                       sts_o,
  output logic [fsp_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
  output logic                                    m_axis_tuser
);
  import fsp_pkg::*;

  // Request registers.
  logic [IDX_W-1:0]   idx_q;
  logic [CAP_W-1:0]   cap_q;
  logic [DIM_W-1:0]   cols_q, rows_q;
  logic [2*DIM_W-1:0] area_q;
  logic               hash_x_q, hash_y_q;
  logic               ok_q;

  // Shell walk.
  logic [DIM_W-1:0]   s_q;
  logic [IDX_W-1:0]   prev_area_q;
  logic [IDX_W-1:0]   rem_q;
  logic [AREA_W-1:0]  pw_q, wdiff_q;
  logic [DIM_W-1:0]   ph_q, hm1_q;

  // Divider.
  logic [DIM_W-1:0]     rmd_q;
  logic [IDX_W-1:0]     dvd_q;
  logic [DIV_CNT_W-1:0] cnt_q;

  // Raw grid coordinate and output register.
  logic [IDX_W-1:0]   x_q;
  logic [DIM_W-1:0]   y_q;
  logic [POS_W-1:0]   pos_x_q, pos_y_q;
  logic               pos_valid_q;

  logic               is_line, is_stag, is_scat;
  logic [AREA_W-1:0]  wlim, hlim;
  logic [DIM_W-1:0]   sp1;
  logic [AREA_W-1:0]  w_raw, pw_raw, w, pw, h13, ph13;
  logic [DIM_W-1:0]   h, ph;
  logic [PROD_W-1:0]  prod, colpart;
  logic [HASH_W-1:0]  hash;
  logic               cap_bad, dim_bad, area_bad;
  logic [DIM_W:0]     trial, trial_sub;
  logic               ge;
  logic [DIM_W-1:0]   rmd_next;
  logic [IDX_W-1:0]   quot_next;
  logic [POS_W-1:0]   x_half, y_half, x_cen, y_cen;
  logic               do_cen;
  logic [POS_W-1:0]   x1, y1, y2, x3, y3;

  assign is_stag = (cfg_i.mode == MODE_STAGGER);
  assign is_line = is_stag || (cfg_i.mode == MODE_RANKS);
  assign is_scat = (cfg_i.mode == MODE_SCATTER);

  // Request checks against capacity, dimensions and grid area.
  assign cap_bad  = (cap_q != '0) && ({1'b0, idx_q} >= cap_q);
  assign dim_bad  = (cols_q == '0) || (rows_q == '0) ||
                    (cols_q > DIM_W'(MAX_DIM)) || (rows_q > DIM_W'(MAX_DIM));
  assign area_bad = ((2*DIM_W)'(idx_q) >= area_q);

  // Multiplicative hash for scatter jitter.
  assign hash = HASH_W'(idx_q) * SCATTER_MUL[HASH_W-1:0];

  // Shell bounds: lines grow wide within the whole area, grids grow square.
  assign wlim = is_line ? area_q[AREA_W-1:0] : AREA_W'(cols_q);
  assign hlim = is_line ? area_q[AREA_W-1:0] : AREA_W'(rows_q);
  assign sp1  = s_q + 1'b1;

  always_comb begin
    case (cfg_i.mode)
      MODE_RANKS: begin
        w_raw  = AREA_W'(sp1) << GROWTH_RANKS_SH;
        pw_raw = AREA_W'(s_q) << GROWTH_RANKS_SH;
      end
      MODE_STAGGER: begin
        w_raw  = AREA_W'(sp1) << GROWTH_STAG_SH;
        pw_raw = AREA_W'(s_q) << GROWTH_STAG_SH;
      end
      default: begin
        w_raw  = AREA_W'(sp1);
        pw_raw = AREA_W'(s_q);
      end
    endcase
  end

  assign w    = (w_raw < wlim) ? w_raw : wlim;
  assign pw   = (pw_raw < wlim) ? pw_raw : wlim;
  assign h13  = (AREA_W'(sp1) < hlim) ? AREA_W'(sp1) : hlim;
  assign ph13 = (AREA_W'(s_q) < hlim) ? AREA_W'(s_q) : hlim;
  assign h    = h13[DIM_W-1:0];
  assign ph   = ph13[DIM_W-1:0];

  // The index lies in this shell once it falls below the shell's full area.
  assign prod = PROD_W'(w) * PROD_W'(h);

  // Slots of the new columns come before the new top row.
  assign colpart = PROD_W'(wdiff_q) * PROD_W'(ph_q);

  // One restoring step of rem / ph.
  assign trial     = {rmd_q, dvd_q[IDX_W-1]};
  assign trial_sub = trial - {1'b0, ph_q};
  assign ge        = (trial >= {1'b0, ph_q});
  assign rmd_next  = ge ? trial_sub[DIM_W-1:0] : trial[DIM_W-1:0];
  assign quot_next = {dvd_q[IDX_W-2:0], ge};

  always_comb begin
    sts_o          = '0;
    sts_o.ok       = !(cap_bad || dim_bad || area_bad);
    sts_o.hit      = (PROD_W'(idx_q) < prod);
    sts_o.use_div  = (PROD_W'(rem_q) < colpart) && (ph_q != '0);
    sts_o.div_last = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
  end

  // Centering: odd rank r goes to (r+1)/2, even rank to -r/2.
  assign x_half = POS_W'(x_q[IDX_W-1:1]);
  assign y_half = POS_W'(y_q[DIM_W-1:1]);
  assign x_cen  = x_q[0] ? x_half + 1'b1 : -x_half;
  assign y_cen  = y_q[0] ? y_half + 1'b1 : -y_half;
  assign do_cen = is_line || cfg_i.centered || is_scat;

  always_comb begin
    x1 = do_cen ? x_cen : POS_W'(x_q);
    y1 = (do_cen && !is_line) ? y_cen : POS_W'(y_q);
    // Stagger interleaves rows by the parity of |x|, which is bit 0 of x.
    y2 = is_stag ? ((y1 << 1) + POS_W'(x1[0])) : y1;
    if (is_scat && (idx_q != '0)) begin
      x3 = {x1[POS_W-2:0], hash_x_q};
      y3 = {y2[POS_W-2:0], hash_y_q};
    end else begin
      x3 = x1;
      y3 = y2;
    end
  end

  // Request capture and setup products.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      idx_q  <= s_axis_tdata[IDX_LSB +: IDX_W];
      cap_q  <= s_axis_tdata[CAP_LSB +: CAP_W];
      cols_q <= s_axis_tdata[COLS_LSB +: DIM_W];
      rows_q <= s_axis_tdata[ROWS_LSB +: DIM_W];
    end
    if (cmd_i.setup) begin
      area_q   <= (2*DIM_W)'(cols_q) * (2*DIM_W)'(rows_q);
      hash_x_q <= hash[HASH_X_BIT];
      hash_y_q <= hash[HASH_Y_BIT];
    end
    if (cmd_i.check) begin
      ok_q <= sts_o.ok;
    end
  end

  // Shell walk: one shell per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      s_q         <= '0;
      prev_area_q <= '0;
    end else if (cmd_i.shell) begin
      if (sts_o.hit) begin
        rem_q   <= idx_q - prev_area_q;
        pw_q    <= pw;
        ph_q    <= ph;
        wdiff_q <= w - pw;
        hm1_q   <= h - 1'b1;
      end else begin
        s_q         <= sp1;
        prev_area_q <= prod[IDX_W-1:0];
      end
    end
  end

  // Column part goes through the divider, top row is placed directly.
  always_ff @(posedge clk_i) begin
    if (cmd_i.colp) begin
      if (sts_o.use_div) begin
        dvd_q <= rem_q;
        rmd_q <= '0;
        cnt_q <= '0;
      end else begin
        x_q <= rem_q - colpart[IDX_W-1:0];
        y_q <= hm1_q;
      end
    end else if (cmd_i.div) begin
      dvd_q <= quot_next;
      rmd_q <= rmd_next;
      cnt_q <= cnt_q + 1'b1;
      if (sts_o.div_last) begin
        x_q <= pw_q[IDX_W-1:0] + quot_next;
        y_q <= rmd_next;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.post_load) begin
      pos_valid_q <= ok_q;
      if (!ok_q) begin
        pos_x_q <= '0;
        pos_y_q <= '0;
      end else if (cfg_i.swap) begin
        pos_x_q <= y3;
        pos_y_q <= x3;
      end else begin
        pos_x_q <= x3;
        pos_y_q <= y3;
      end
    end
  end

  assign m_axis_tdata = {(OUT_TDATA_W - OUT_BITS)'(0), pos_y_q, pos_x_q};
  assign m_axis_tuser = pos_valid_q;

  `FSP_ASSERT_NOW(a_div_nonzero, cmd_i.div, ph_q != '0, "divide by zero height")
  `FSP_ASSERT_NOW(a_prev_below_idx, cmd_i.shell, prev_area_q <= idx_q, "shell walk passed the index")
  `FSP_ASSERT_NOW(a_shell_bound, cmd_i.shell, s_q < DIM_W'(MAX_DIM), "shell count out of range")

endmodule

`default_nettype wire

// ===== rtl/formation_slot_position_top.sv =====
// Timing: an invalid request passes through setup, check and post before its result is
// loaded; a valid one also walks the shells, one shell per cycle (up to 64 shells), and
// when the slot lies in the new columns goes through the bit-serial divider before post.
// Flow: one request at a time; the next is taken in the cycle after the result is
// loaded into the output register, which holds it while the next request runs.
// Reset: asynchronous, active low; clears the sequencer, result valid and the
// configuration registers, while the datapath registers are loaded before they are used.
`default_nettype none

module formation_slot_position_top (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Request stream.
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // slot_index[11:0], slot_capacity[24:12], grid_cols[31:25], grid_rows[38:32]
  input  wire logic [fsp_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // Result stream.
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // pos_x[14:0], pos_y[29:15]
  output logic [fsp_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
  // pos_valid[0]
  output logic                                  m_axis_tuser,
  // Configuration port.
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [fsp_pkg::PADDR_W-1:0]      paddr,
  input  wire logic [31:0]                      pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);
  import fsp_pkg::*;

  shape_mode_e shape_mode_q;
  logic        centered_q;
  logic        swap_q;
  logic        cfg_write;
  logic [1:0]  reg_sel;
  fsp_cfg_t    cfg;
  fsp_cmd_t    cmd;
  fsp_sts_t    sts;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_sel   = paddr[PADDR_W-1:2];

  // Register writes on the access phase of a transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_mode_q <= MODE_GRID;
      centered_q   <= 1'b0;
      swap_q       <= 1'b0;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_SHAPE_MODE:  shape_mode_q <= shape_mode_e'(pwdata[1:0]);
        REG_CENTERED_ON: centered_q   <= pwdata[0];
        REG_SWAP_AXES:   swap_q       <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // Register reads.
  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_SHAPE_MODE:  prdata = 32'(shape_mode_q);
      REG_CENTERED_ON: prdata = 32'(centered_q);
      REG_SWAP_AXES:   prdata = 32'(swap_q);
      default:         prdata = '0;
    endcase
  end

  assign cfg.mode     = shape_mode_q;
  assign cfg.centered = centered_q;
  assign cfg.swap     = swap_q;

  fsp_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  fsp_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

endmodule

`default_nettype wire
